// ----- hw/rtl/bpf_pkg.sv -----
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared types, codes and defaults for the banked priority FIFO.
// ----------------------------------------------------------------------------
package bpf_pkg;

  // Default geometry
  localparam int NUM_ROWS_DEF  = 4;
  localparam int ROW_DEPTH_DEF = 8;

  // Fixed field widths
  localparam int CMD_W  = 1;
  localparam int ROW_W  = 2;
  localparam int VAL_W  = 8;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // perform the latched request
  } ctrl_t;

endpackage

// ----- hw/rtl/bpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpf_ctrl
// Request sequencer: accept, execute, present result.
// ----------------------------------------------------------------------------
module bpf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output bpf_pkg::ctrl_t ctl
);
  import bpf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, valid_r;
  logic   accept;

  assign accept = start & ~busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_DONE;
      S_DONE:  state_nxt = accept ? S_EXEC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt == S_EXEC);
      valid_r <= (state_nxt == S_DONE);
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;
  assign ctl.load  = accept;
  assign ctl.exec  = (state_r == S_EXEC);

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && ctl.exec))
    else $error("accepted request not executed");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> (valid_r && !ctl.exec))
    else $error("execute not followed by result strobe");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe longer than one cycle");

endmodule

// ----- hw/rtl/bpf_datapath.sv -----
// ----------------------------------------------------------------------------
// bpf_datapath
// Row pointers, slot memory and result registers.
// ----------------------------------------------------------------------------
module bpf_datapath #(
  parameter int NUM_ROWS  = bpf_pkg::NUM_ROWS_DEF,
  parameter int ROW_DEPTH = bpf_pkg::ROW_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bpf_pkg::ctrl_t             ctl,
  input  logic [bpf_pkg::CMD_W-1:0]  in_command,
  input  logic [bpf_pkg::ROW_W-1:0]  in_row,
  input  logic [bpf_pkg::VAL_W-1:0]  in_value,
  output logic [bpf_pkg::VAL_W-1:0]  out_data,
  output logic [bpf_pkg::STAT_W-1:0] out_status,
  output logic [bpf_pkg::OCC_W-1:0]  out_occupancy
);
  import bpf_pkg::*;

  localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int HW = $clog2(ROW_DEPTH);
  localparam int CW = $clog2(ROW_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int MD = NUM_ROWS * ROW_DEPTH;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;

  // Latched request
  logic [CMD_W-1:0] cmd_r;
  logic [ROW_W-1:0] row_r;
  logic [VAL_W-1:0] val_r;

  // Per-row pointers
  logic [HW-1:0] head_r  [NUM_ROWS];
  logic [CW-1:0] count_r [NUM_ROWS];

  // Slot memory, contents undefined until written
  logic [VAL_W-1:0] mem [MD];

  // Result registers
  logic [VAL_W-1:0]  rd_data_r;
  logic              data_ok_r;
  logic [STAT_W-1:0] status_r;
  logic [OCC_W-1:0]  occ_r;

  logic              in_range;
  logic [RW-1:0]     row_idx;
  logic [HW-1:0]     cur_head, head_inc;
  logic [CW-1:0]     cur_cnt, occ_nxt;
  logic [SW-1:0]     tail_sum, tail_wrap;
  logic [HW-1:0]     tail;
  logic [AW-1:0]     base, wr_addr, rd_addr;
  logic              full, empty, enq_ok, deq_ok;
  logic [STAT_W-1:0] status_nxt;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      row_r <= in_row;
      val_r <= in_value;
    end
  end

  assign in_range = (32'(row_r) < NUM_ROWS);
  assign row_idx  = RW'(row_r);
  assign cur_head = in_range ? head_r[row_idx]  : '0;
  assign cur_cnt  = in_range ? count_r[row_idx] : '0;
  assign full     = (cur_cnt == CW'(ROW_DEPTH));
  assign empty    = (cur_cnt == '0);
  assign enq_ok   = in_range && (cmd_r == CMD_ENQ) && !full;
  assign deq_ok   = in_range && (cmd_r == CMD_DEQ) && !empty;

  // Tail = (head + count) mod depth; the sum stays below twice the depth
  assign tail_sum  = SW'(cur_head) + SW'(cur_cnt);
  assign tail_wrap = (tail_sum >= SW'(ROW_DEPTH)) ? tail_sum - SW'(ROW_DEPTH) : tail_sum;
  assign tail      = HW'(tail_wrap);
  assign head_inc  = (cur_head == HW'(ROW_DEPTH - 1)) ? '0 : cur_head + HW'(1);

  assign base    = AW'(32'(row_idx) * ROW_DEPTH);
  assign wr_addr = base + AW'(tail);
  assign rd_addr = base + AW'(cur_head);

  always_comb begin
    if (enq_ok)      occ_nxt = cur_cnt + CW'(1);
    else if (deq_ok) occ_nxt = cur_cnt - CW'(1);
    else             occ_nxt = cur_cnt;
  end

  always_comb begin
    if (cmd_r == CMD_ENQ) status_nxt = enq_ok ? ST_OK : ST_FULL;
    else                  status_nxt = deq_ok ? ST_OK : ST_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (ctl.exec && (enq_ok || deq_ok)) begin
      count_r[row_idx] <= occ_nxt;
      if (deq_ok) begin
        head_r[row_idx] <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && enq_ok) begin
      mem[wr_addr] <= val_r;
    end
    if (ctl.exec && deq_ok) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      data_ok_r <= deq_ok;
      status_r  <= status_nxt;
      occ_r     <= OCC_W'(occ_nxt);
    end
  end

  assign out_data      = data_ok_r ? rd_data_r : '0;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |-> (cur_cnt <= CW'(ROW_DEPTH)))
    else $error("row count beyond depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && enq_ok) |=> (count_r[$past(row_idx)] == $past(cur_cnt) + CW'(1)))
    else $error("enqueue did not advance count");

  a_deq_head: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && deq_ok) |=> (head_r[$past(row_idx)] == $past(head_inc)))
    else $error("dequeue did not advance head");

endmodule

// ----- hw/rtl/banked_priority_fifo.sv -----
// ----------------------------------------------------------------------------
// banked_priority_fifo
// Bank of circular byte FIFOs, one per priority row, behind a command port.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low.
// busy is high in the execute state after that edge while the request runs. The
// result then sits on the out_ ports with out_valid high for exactly one
// cycle. The receiver cannot stall the result, so capture it on that cycle.
// busy is already low during the result cycle, so a new request can be issued
// then; no request is taken while one executes. The taking edge only latches
// the request in the request register; the execute state then performs it and
// loads the result registers. Enqueue to a full row reports status full;
// dequeue from an empty row reports status empty; a row number of NUM_ROWS or
// more behaves as a row of zero capacity. In all failure cases nothing changes
// and out_data is zero. Slot memory has no reset; head and count registers
// clear on reset, so no slot is read before written.
// ----------------------------------------------------------------------------
module banked_priority_fifo #(
  parameter int NUM_ROWS  = bpf_pkg::NUM_ROWS_DEF,
  parameter int ROW_DEPTH = bpf_pkg::ROW_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request side
  input  logic                       start,
  output logic                       busy,
  input  logic [bpf_pkg::CMD_W-1:0]  in_command,
  input  logic [bpf_pkg::ROW_W-1:0]  in_row,
  input  logic [bpf_pkg::VAL_W-1:0]  in_value,
  // result side
  output logic                       out_valid,
  output logic [bpf_pkg::VAL_W-1:0]  out_data,
  output logic [bpf_pkg::STAT_W-1:0] out_status,
  output logic [bpf_pkg::OCC_W-1:0]  out_occupancy
);
  import bpf_pkg::*;

  ctrl_t ctl;

  // Sequencer: idle -> execute -> result
  bpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // Pointers, slot memory and result registers
  bpf_datapath #(
    .NUM_ROWS  (NUM_ROWS),
    .ROW_DEPTH (ROW_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_command    (in_command),
    .in_row        (in_row),
    .in_value      (in_value),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  // Failed requests never carry data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_data == '0))
    else $error("failed request returned data");

  // Empty status only with an empty row
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_occupancy == '0))
    else $error("empty status with nonzero occupancy");

endmodule
